// ----- rtl/ads_pkg.sv -----
`default_nettype none

package ads_pkg;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_ITER  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } act_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TANG,
        ST_TPH,
        ST_TT2,
        ST_TP1,
        ST_TP2,
        ST_TR,
        ST_MMUL,
        ST_MACC,
        ST_ZUPD,
        ST_SCALE,
        ST_DINIT,
        ST_DIV,
        ST_DEND,
        ST_CW1,
        ST_CW2,
        ST_CWR,
        ST_RDI,
        ST_RDD,
        ST_DONE
    } state_t;

    // what the divider result is for
    typedef enum logic [1:0] {
        JOB_X  = 2'd0,
        JOB_Y  = 2'd1,
        JOB_RD = 2'd2,
        JOB_NA = 2'd3
    } job_t;

    // divider geometry: 48-bit dividend, 32-bit divisor
    localparam int DVD_W = 48;
    localparam int DSR_W = 32;

    // 1/(2*pi) in Q0.32
    localparam logic [29:0] INV_2PI = 30'd683565276;

    // quarter-wave polynomial constants
    localparam logic [14:0] POLY_C0 = 15'd10530;
    localparam logic [10:0] POLY_C1 = 11'd1191;
    localparam logic [14:0] POLY_C2 = 15'd25736;
    localparam logic [12:0] TRIG_ONE = 13'd4096;

    // reset values
    localparam logic signed [15:0] COEF_RST = 16'sd4096;
    localparam logic signed [17:0] PT_ONE   = 18'sd4096;

    // bias of the weight: 2.0 in Q.12
    localparam logic signed [15:0] W_BIAS = 16'sd8192;

endpackage

`default_nettype wire

// ----- rtl/attractor_density_splatter.sv -----
`default_nettype none

// Density splatter for a generalised Clifford attractor. Each iterate word
// advances the point and adds a bilinear footprint of weight (z+2)/4 into a
// GRID_COLS x GRID_ROWS store held in a synchronous RAM with separate read
// and write addresses; a read word returns one cell, the peak and cell/peak
// in Q0.16; a clear word zeroes the store and the peak. One item is in work
// at a time. An iterate runs six sine/cosine evaluations through one shared
// polynomial unit (angle, phase, fold, polynomial and result states), the
// multiply-accumulate passes, two passes of a 48-step restoring divider (one
// quotient bit per cycle) for the grid mapping, and a weight, increment and
// write step on the RAM for each corner. A read uses the same divider. After
// reset, and for each clear word, the RAM is swept at one entry per cycle,
// during which no item is taken (coefficient writes are still accepted). A
// result waits in an output register and the next item may be taken meanwhile.
module attractor_density_splatter
    import ads_pkg::*;
#(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // col[7:0], row[15:8]
    input  wire logic [1:0]   s_tuser,   // action[1:0]
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // point_x[17:0], point_y[35:18], cell_value[67:36], peak_value[99:68],
    // density[115:100], zero pad[119:116]
    output logic [119:0]      m_tdata,
    // coefficient writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam int DEPTH  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int DCNT_W = $clog2(DVD_W);

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    logic [ADDR_W-1:0]       clr_cnt_reg;
    logic                    clr_resp_reg;
    act_t                    act_reg;

    logic signed [15:0]      coef_reg [0:7];
    logic signed [17:0]      cur_x_reg, cur_y_reg;
    logic signed [15:0]      cur_z_reg;
    logic [31:0]             peak_reg;

    // trig unit
    logic [2:0]              tidx_reg;
    logic signed [33:0]      ang_reg;
    logic [15:0]             phase_reg;
    logic [1:0]              quad_reg;
    logic [14:0]             t_reg, t2_reg, p_reg;
    logic signed [13:0]      trig_reg [0:5];

    // multiply-accumulate
    logic [1:0]              k_reg;
    logic signed [29:0]      prod_reg;
    logic signed [30:0]      acc_reg;
    logic signed [17:0]      nx_reg, ny_reg;
    logic signed [15:0]      w_reg;

    // divider
    job_t                    job_reg;
    logic signed [31:0]      num_reg;
    logic [DVD_W-1:0]        dq_reg;
    logic [DSR_W-1:0]        rem_reg, dsr_reg;
    logic                    neg_reg;
    logic [DCNT_W-1:0]       dcnt_reg;

    // grid position and corners
    logic signed [32:0]      ix_reg, iy_reg;
    logic signed [17:0]      ex_reg, ey_reg;
    logic [1:0]              corner_reg;
    logic signed [35:0]      wxy_reg;
    logic signed [15:0]      inc_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic                    inrng_reg;

    // density RAM
    logic [31:0]             density_mem [0:DEPTH-1];
    logic [31:0]             rd_data_reg;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [31:0]             mem_wdata;

    // read result
    logic [31:0]             cell_reg;
    logic [15:0]             dens_reg;

    // output register
    logic                    m_tvalid_reg;
    logic [119:0]            m_tdata_reg;
    logic                    out_load;

    // ---------------------------------------------------------------- input decode
    act_t                    in_act;
    logic [7:0]              in_col, in_row;
    logic                    in_rng;
    logic [ADDR_W-1:0]       in_addr;

    assign in_act  = act_t'(s_tuser);
    assign in_col  = s_tdata[7:0];
    assign in_row  = s_tdata[15:8];
    assign in_rng  = (32'(in_col) < 32'(GRID_COLS)) && (32'(in_row) < 32'(GRID_ROWS));
    assign in_addr = ADDR_W'(32'(in_row) * 32'(GRID_COLS) + 32'(in_col));

    // ---------------------------------------------------------------- trig datapath
    logic signed [33:0]      ang_c;
    logic signed [64:0]      ph_prod;
    logic [15:0]             phase_c;
    logic [14:0]             t_c, t2_c, p1_c, p2_c;
    logic [29:0]             tt_c, m2_c, m3_c;
    logic [25:0]             m1_c;
    logic [15:0]             r_c, s0_c;
    logic [12:0]             s_c;
    logic signed [13:0]      trig_c;

    // angle per evaluation: sin(by), cos(dx), sin(fx), cos(hy), sin(x), cos(z)
    always_comb begin
        unique case (tidx_reg)
            3'd0:    ang_c = 34'(coef_reg[1]) * 34'(cur_y_reg);
            3'd1:    ang_c = 34'(coef_reg[3]) * 34'(cur_x_reg);
            3'd2:    ang_c = 34'(coef_reg[5]) * 34'(cur_x_reg);
            3'd3:    ang_c = 34'(coef_reg[7]) * 34'(cur_y_reg);
            3'd4:    ang_c = 34'(cur_x_reg) <<< 12;
            3'd5:    ang_c = 34'(cur_z_reg) <<< 12;
            default: ang_c = '0;
        endcase
    end

    // turn fraction; cosine is a quarter turn ahead
    assign ph_prod = 65'(ang_reg) * $signed(65'(INV_2PI));
    assign phase_c = ph_prod[55:40] + (tidx_reg[0] ? 16'h4000 : 16'h0000);

    // quarter-wave fold and polynomial
    assign t_c  = phase_reg[14] ? (15'd16384 - {1'b0, phase_reg[13:0]})
                                : {1'b0, phase_reg[13:0]};
    assign tt_c = 30'(t_c) * 30'(t_c);
    assign t2_c = tt_c[28:14];
    assign m1_c = 26'(POLY_C1) * 26'(t2_reg);
    assign p1_c = POLY_C0 - 15'(m1_c >> 14);
    assign m2_c = 30'(p_reg) * 30'(t2_reg);
    assign p2_c = POLY_C2 - 15'(m2_c >> 14);
    assign m3_c = 30'(t_reg) * 30'(p_reg);
    assign r_c  = 16'(m3_c >> 14);
    assign s0_c = (r_c + 16'd2) >> 2;
    assign s_c  = (s0_c > 16'(TRIG_ONE)) ? TRIG_ONE : s0_c[12:0];
    assign trig_c = quad_reg[1] ? -$signed({1'b0, s_c}) : $signed({1'b0, s_c});

    // ---------------------------------------------------------------- MAC datapath
    logic signed [29:0]      prod_c;
    logic signed [30:0]      sum_c;
    logic signed [18:0]      rnd_c;
    logic signed [17:0]      sat_c;
    logic signed [16:0]      spx_c, spy_c;

    assign prod_c = 30'(coef_reg[{k_reg, 1'b0}]) * 30'(trig_reg[{1'b0, k_reg}]);
    assign sum_c  = acc_reg + 31'(prod_reg);
    assign rnd_c  = 19'((sum_c + 31'sd2048) >>> 12);

    always_comb begin
        priority if (rnd_c > 19'sd131071) sat_c = 18'sd131071;
        else if (rnd_c < -19'sd131072)    sat_c = -18'sd131072;
        else                              sat_c = rnd_c[17:0];
    end

    assign spx_c = 17'(coef_reg[0]) + 17'(coef_reg[2]);
    assign spy_c = 17'(coef_reg[4]) + 17'(coef_reg[6]);

    // ---------------------------------------------------------------- scaling and divider
    logic signed [18:0]      base_c;
    logic signed [31:0]      num_c;
    logic [31:0]             num_mag;
    logic signed [16:0]      sp_c;
    logic [16:0]             sp_mag;
    logic [DSR_W:0]          rem_sh;
    logic                    div_ge;
    logic [DSR_W-1:0]        rem_n;
    logic signed [32:0]      qi_c;
    logic signed [17:0]      qf_c;

    assign base_c  = (job_reg == JOB_Y) ? (19'(ny_reg) + 19'(spy_c))
                                        : (19'(nx_reg) + 19'(spx_c));
    assign num_c   = 32'(base_c) * ((job_reg == JOB_Y) ? 32'(GRID_ROWS) : 32'(GRID_COLS));
    assign num_mag = num_reg[31] ? 32'(-num_reg) : 32'(num_reg);
    assign sp_c    = (job_reg == JOB_Y) ? spy_c : spx_c;
    assign sp_mag  = sp_c[16] ? 17'(-sp_c) : 17'(sp_c);

    // one restoring step per cycle
    assign rem_sh = {rem_reg, dq_reg[DVD_W-1]};
    assign div_ge = rem_sh >= {1'b0, dsr_reg};
    assign rem_n  = div_ge ? DSR_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DSR_W-1:0];

    // quotient is toward zero: integer part and signed Q.16 fraction
    assign qi_c = neg_reg ? -$signed({1'b0, dq_reg[47:16]}) : $signed({1'b0, dq_reg[47:16]});
    assign qf_c = neg_reg ? -$signed({2'b0, dq_reg[15:0]}) : $signed({2'b0, dq_reg[15:0]});

    // ---------------------------------------------------------------- corner datapath
    logic signed [17:0]      wx_c, wy_c;
    logic signed [32:0]      ccol_c, crow_c;
    logic                    cin_c;
    logic signed [51:0]      p52_c;
    logic signed [33:0]      v_c;
    logic [31:0]             vsat_c;

    assign wx_c   = corner_reg[0] ? ex_reg : (18'sd65536 - ex_reg);
    assign wy_c   = corner_reg[1] ? ey_reg : (18'sd65536 - ey_reg);
    assign ccol_c = ix_reg + $signed({32'b0, corner_reg[0]});
    assign crow_c = iy_reg + $signed({32'b0, corner_reg[1]});
    assign cin_c  = (ccol_c >= 33'sd0) && (ccol_c < 33'(GRID_COLS))
                 && (crow_c >= 33'sd0) && (crow_c < 33'(GRID_ROWS));

    assign p52_c = 52'(wxy_reg) * 52'(w_reg);

    // saturating add into the cell
    assign v_c = $signed({2'b0, rd_data_reg}) + 34'(inc_reg);
    always_comb begin
        priority if (v_c < 34'sd0)        vsat_c = 32'd0;
        else if (v_c > 34'sd4294967295)   vsat_c = 32'hFFFF_FFFF;
        else                              vsat_c = v_c[31:0];
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = clr_resp_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (in_act)
                        ACT_ITER:  state_next = ST_TANG;
                        ACT_READ:  state_next = ST_RDI;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_NONE:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_TANG: state_next = ST_TPH;
            ST_TPH:  state_next = ST_TT2;
            ST_TT2:  state_next = ST_TP1;
            ST_TP1:  state_next = ST_TP2;
            ST_TP2:  state_next = ST_TR;
            ST_TR:   state_next = (tidx_reg == 3'd5) ? ST_MMUL : ST_TANG;
            ST_MMUL: state_next = ST_MACC;
            ST_MACC: state_next = (k_reg == 2'd3) ? ST_ZUPD : ST_MMUL;
            ST_ZUPD: begin
                state_next = (spx_c == 17'sd0 || spy_c == 17'sd0) ? ST_DONE : ST_SCALE;
            end
            ST_SCALE: state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV: begin
                if (dcnt_reg == DCNT_W'(DVD_W - 1)) begin
                    state_next = ST_DEND;
                end
            end
            ST_DEND: begin
                unique case (job_reg)
                    JOB_X:   state_next = ST_SCALE;
                    JOB_Y:   state_next = ST_CW1;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_CW1: state_next = ST_CW2;
            ST_CW2: state_next = ST_CWR;
            ST_CWR: begin
                mem_we     = inrng_reg;
                state_next = (corner_reg == 2'd3) ? ST_DONE : ST_CW1;
            end
            ST_RDI: state_next = ST_RDD;
            ST_RDD: begin
                state_next = (inrng_reg && peak_reg != 32'd0) ? ST_DIV : ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            cur_x_reg    <= PT_ONE;
            cur_y_reg    <= PT_ONE;
            cur_z_reg    <= 16'(PT_ONE);
            peak_reg     <= '0;
            for (int i = 0; i < 8; i++) begin
                coef_reg[i] <= COEF_RST;
            end
        end else begin
            if (cfg_valid) begin
                coef_reg[cfg_index] <= cfg_data;
            end
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (state_reg == ST_IDLE && s_tvalid && in_act == ACT_CLEAR) begin
                clr_cnt_reg  <= '0;
                clr_resp_reg <= 1'b1;
                peak_reg     <= '0;
            end
            if (state_reg == ST_ZUPD) begin
                cur_x_reg <= nx_reg;
                cur_y_reg <= ny_reg;
                cur_z_reg <= 16'(trig_reg[4]) + 16'(trig_reg[5]);
            end
            if (state_reg == ST_CWR && inrng_reg && vsat_c > peak_reg) begin
                peak_reg <= vsat_c;
            end
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                act_reg   <= in_act;
                tidx_reg  <= '0;
                addr_reg  <= in_addr;
                inrng_reg <= in_rng;
                cell_reg  <= '0;
                dens_reg  <= '0;
            end
            ST_TANG: ang_reg <= ang_c;
            ST_TPH:  phase_reg <= phase_c;
            ST_TT2: begin
                t_reg    <= t_c;
                t2_reg   <= t2_c;
                quad_reg <= phase_reg[15:14];
            end
            ST_TP1: p_reg <= p1_c;
            ST_TP2: p_reg <= p2_c;
            ST_TR: begin
                trig_reg[tidx_reg] <= trig_c;
                tidx_reg           <= tidx_reg + 3'd1;
                k_reg              <= '0;
            end
            ST_MMUL: prod_reg <= prod_c;
            ST_MACC: begin
                k_reg <= k_reg + 2'd1;
                if (!k_reg[0]) begin
                    acc_reg <= 31'(prod_reg);
                end else if (k_reg == 2'd1) begin
                    nx_reg <= sat_c;
                end else begin
                    ny_reg <= sat_c;
                end
            end
            ST_ZUPD: begin
                w_reg   <= 16'(trig_reg[4]) + 16'(trig_reg[5]) + W_BIAS;
                job_reg <= JOB_X;
            end
            ST_SCALE: num_reg <= num_c;
            ST_DINIT: begin
                dq_reg   <= {num_mag, 16'b0};
                rem_reg  <= '0;
                dsr_reg  <= DSR_W'({sp_mag, 1'b0});
                neg_reg  <= num_reg[31] ^ sp_c[16];
                dcnt_reg <= '0;
            end
            ST_DIV: begin
                rem_reg  <= rem_n;
                dq_reg   <= {dq_reg[DVD_W-2:0], div_ge};
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            ST_DEND: begin
                unique case (job_reg)
                    JOB_X: begin
                        ix_reg  <= qi_c;
                        ex_reg  <= qf_c;
                        job_reg <= JOB_Y;
                    end
                    JOB_Y: begin
                        iy_reg     <= qi_c;
                        ey_reg     <= qf_c;
                        corner_reg <= '0;
                    end
                    default: begin
                        dens_reg <= (|dq_reg[47:16]) ? 16'hFFFF : dq_reg[15:0];
                    end
                endcase
            end
            ST_CW1: begin
                wxy_reg   <= 36'(wx_c) * 36'(wy_c);
                inrng_reg <= cin_c;
                addr_reg  <= ADDR_W'(32'(crow_c[ROW_W-1:0]) * 32'(GRID_COLS)
                                     + 32'(ccol_c[COL_W-1:0]));
            end
            ST_CW2: inc_reg <= 16'((p52_c + 52'sd137438953472) >>> 38);
            ST_CWR: corner_reg <= corner_reg + 2'd1;
            ST_RDD: begin
                cell_reg <= inrng_reg ? rd_data_reg : 32'd0;
                job_reg  <= JOB_RD;
                dq_reg   <= {rd_data_reg, 16'b0};
                rem_reg  <= '0;
                dsr_reg  <= peak_reg;
                neg_reg  <= 1'b0;
                dcnt_reg <= '0;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- density RAM
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? 32'd0 : vsat_c;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            density_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= density_mem[addr_reg];
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'b0,
                            (act_reg == ACT_READ) ? dens_reg : 16'd0,
                            peak_reg,
                            (act_reg == ACT_READ) ? cell_reg : 32'd0,
                            (act_reg == ACT_ITER) ? cur_y_reg : 18'sd0,
                            (act_reg == ACT_ITER) ? cur_x_reg : 18'sd0};
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    // a cell written by a splat never exceeds the peak that follows it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CWR && mem_we) |=> (peak_reg >= $past(mem_wdata)))
        else $error("peak below a written cell");

    // a clear word drops the peak and starts the sweep at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == ACT_CLEAR)
        |=> (peak_reg == 32'd0 && state_reg == ST_CLEAR))
        else $error("clear did not start");

    // divider partial remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < dsr_reg))
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
